FILE: design/ppd_pkg.sv
// shared constants for the point-to-polyline distance core
package ppd_pkg;
   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 8;
   localparam int OUT_BITS   = 25;
   localparam int OUT_DATA_BITS = ((OUT_BITS + 7) / 8) * 8;
endpackage

FILE: design/point_to_polyline_min_distance_core.sv
// top level of the point-to-polyline least distance core
//
//  channel | dir | transfer carries
//  --------+-----+------------------------------------------------------------
//  req_    | in  | query point and one vertex, tlast marks the last vertex
//  rsp_    | out | least distance of the polyline, FRAC_BITS fraction bits
//
// one vertex passes an accept state, the multiply steps and a pick state, then
// either the root unit alone (endpoint distance) or the cross product square
// steps, the serial divider and the root unit (perpendicular distance).
// req_tready is high only while idle.
// reset is synchronous and clears control state and the running minimum.
// a last vertex then passes through a final state, waiting
// there until the result register is free.
module point_to_polyline_min_distance_core #(
   parameter int COORD_BITS = ppd_pkg::COORD_BITS,
   parameter int FRAC_BITS  = ppd_pkg::FRAC_BITS
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // query_x, query_y, vertex_x, vertex_y from bit 0 up
   input  logic [((4*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic req_tlast,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // min_distance from bit 0 up
   output logic [ppd_pkg::OUT_DATA_BITS-1:0] rsp_tdata
);
   localparam int CB     = COORD_BITS;
   localparam int DW     = CB + 1;          // coordinate difference
   localparam int MW     = DW + 1;          // multiplier operand
   localparam int PW     = 2 * MW;          // product
   localparam int SQW    = 2 * DW;          // sum of two squares, cross product magnitude
   localparam int CSW    = 4 * DW;          // squared cross product
   localparam int NUM_W  = CSW + 2 * FRAC_BITS;
   localparam int ROOT_W = NUM_W / 2;
   localparam int OB     = ppd_pkg::OUT_BITS;
   localparam int XW     = (ROOT_W > OB) ? ROOT_W : OB;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL, S_PICK, S_CSQ, S_DIV_GO, S_DIV_WAIT, S_SQ_GO, S_SQ_WAIT, S_OUT
   } state_type;

   state_type state_ff;

   logic signed [CB-1:0] qx_ff, qy_ff, px_ff, py_ff, vx_ff, vy_ff;
   logic                 last_ff, first_ff, have_prev_ff;
   logic [OB-1:0]        best_ff;
   logic [SQW-1:0]       d0_ff, d1_ff, n2_ff, cabs_ff;
   logic signed [SQW:0]  cr_ff;
   logic [CSW-1:0]       csq_ff;
   logic [NUM_W-1:0]     rad_ff;
   logic [3:0]           step_ff;
   logic                 rsp_valid_ff;
   logic [OB-1:0]        rsp_data_ff;

   // differences: a is the previous vertex, b the current one, q the query
   logic signed [DW-1:0] dxa, dya, dxb, dyb, nx, ny;
   assign dxa = DW'(qx_ff) - DW'(px_ff);
   assign dya = DW'(qy_ff) - DW'(py_ff);
   assign dxb = DW'(qx_ff) - DW'(vx_ff);
   assign dyb = DW'(qy_ff) - DW'(vy_ff);
   assign nx  = DW'(px_ff) - DW'(vx_ff);
   assign ny  = DW'(py_ff) - DW'(vy_ff);

   // shared multiplier, operands chosen by the step counter
   logic [DW-1:0]        c_hi, c_lo;
   logic signed [MW-1:0] ma, mb;
   logic signed [PW-1:0] prod;
   assign c_hi = cabs_ff[SQW-1:DW];
   assign c_lo = cabs_ff[DW-1:0];

   always_comb begin
      case (step_ff)
         4'd0:    begin ma = MW'(dxa); mb = MW'(dxa); end
         4'd1:    begin ma = MW'(dya); mb = MW'(dya); end
         4'd2:    begin ma = MW'(dxb); mb = MW'(dxb); end
         4'd3:    begin ma = MW'(dyb); mb = MW'(dyb); end
         4'd4:    begin ma = MW'(nx);  mb = MW'(nx);  end
         4'd5:    begin ma = MW'(ny);  mb = MW'(ny);  end
         4'd6:    begin ma = MW'(nx);  mb = MW'(dya); end
         4'd7:    begin ma = MW'(ny);  mb = MW'(dxa); end
         4'd8:    begin ma = $signed({1'b0, c_hi}); mb = $signed({1'b0, c_hi}); end
         4'd9:    begin ma = $signed({1'b0, c_hi}); mb = $signed({1'b0, c_lo}); end
         4'd10:   begin ma = $signed({1'b0, c_lo}); mb = $signed({1'b0, c_lo}); end
         default: begin ma = '0; mb = '0; end
      endcase
   end
   assign prod = ma * mb;

   logic [SQW-1:0]  pmin;
   logic [SQW:0]    cr_mag;
   assign pmin   = (d0_ff < d1_ff) ? d0_ff : d1_ff;
   assign cr_mag = cr_ff[SQW] ? (SQW+1)'(-cr_ff) : (SQW+1)'(cr_ff);

   // serial units
   logic             div_start, div_done, sq_start, sq_done;
   logic [NUM_W-1:0] quot;
   logic [ROOT_W-1:0] root;

   assign div_start = (state_ff == S_DIV_GO);
   assign sq_start  = (state_ff == S_SQ_GO);

   ppd_div #(.NUM_W(NUM_W), .DEN_W(SQW)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (NUM_W'(csq_ff) << (2 * FRAC_BITS)),
      .divisor  (n2_ff),
      .done     (div_done),
      .quotient (quot)
   );

   ppd_isqrt #(.RAD_W(NUM_W)) u_isqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (rad_ff),
      .done     (sq_done),
      .root     (root)
   );

   // saturate the root to the result width
   logic [XW-1:0] root_x;
   logic [OB-1:0] root_sat;
   assign root_x   = XW'(root);
   assign root_sat = (root_x > XW'({OB{1'b1}})) ? {OB{1'b1}} : OB'(root_x);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         have_prev_ff <= 1'b0;
         best_ff      <= '0;
         px_ff        <= '0;
         py_ff        <= '0;
         qx_ff        <= '0;
         qy_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         // the final state reloads the result register itself
         if (rsp_valid_ff && rsp_tready && state_ff != S_OUT) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_tvalid) begin
                  vx_ff    <= req_tdata[2*CB +: CB];
                  vy_ff    <= req_tdata[3*CB +: CB];
                  last_ff  <= req_tlast;
                  first_ff <= !have_prev_ff;
                  if (!have_prev_ff) begin
                     qx_ff <= req_tdata[0 +: CB];
                     qy_ff <= req_tdata[CB +: CB];
                  end
                  step_ff  <= '0;
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               case (step_ff)
                  4'd0:    d0_ff <= SQW'(prod);
                  4'd1:    d0_ff <= d0_ff + SQW'(prod);
                  4'd2:    d1_ff <= SQW'(prod);
                  4'd3:    d1_ff <= d1_ff + SQW'(prod);
                  4'd4:    n2_ff <= SQW'(prod);
                  4'd5:    n2_ff <= n2_ff + SQW'(prod);
                  4'd6:    cr_ff <= (SQW+1)'(prod);
                  default: cr_ff <= cr_ff - (SQW+1)'(prod);
               endcase
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd7) begin
                  state_ff <= S_PICK;
               end
            end
            S_PICK: begin
               // single vertex, zero-length segment, endpoint or perpendicular
               if (first_ff) begin
                  rad_ff   <= NUM_W'(d1_ff) << (2 * FRAC_BITS);
                  state_ff <= S_SQ_GO;
               end else if (n2_ff == '0) begin
                  rad_ff   <= NUM_W'(d0_ff) << (2 * FRAC_BITS);
                  state_ff <= S_SQ_GO;
               end else if (n2_ff < d0_ff || n2_ff < d1_ff) begin
                  rad_ff   <= NUM_W'(pmin) << (2 * FRAC_BITS);
                  state_ff <= S_SQ_GO;
               end else begin
                  cabs_ff  <= SQW'(cr_mag);
                  step_ff  <= 4'd8;
                  state_ff <= S_CSQ;
               end
            end
            S_CSQ: begin
               // cross product squared from its high and low halves
               case (step_ff)
                  4'd8:    csq_ff <= CSW'(prod) << SQW;
                  4'd9:    csq_ff <= csq_ff + (CSW'(prod) << (DW + 1));
                  default: csq_ff <= csq_ff + CSW'(prod);
               endcase
               step_ff <= step_ff + 1'b1;
               if (step_ff == 4'd10) begin
                  state_ff <= S_DIV_GO;
               end
            end
            S_DIV_GO: begin
               state_ff <= S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
               if (div_done) begin
                  rad_ff   <= quot;
                  state_ff <= S_SQ_GO;
               end
            end
            S_SQ_GO: begin
               state_ff <= S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
               if (sq_done) begin
                  if (first_ff || root_sat < best_ff) begin
                     best_ff <= root_sat;
                  end
                  px_ff        <= vx_ff;
                  py_ff        <= vy_ff;
                  have_prev_ff <= 1'b1;
                  state_ff     <= last_ff ? S_OUT : S_IDLE;
               end
            end
            S_OUT: begin
               // hold until the result register is free
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= best_ff;
                  have_prev_ff <= 1'b0;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = ppd_pkg::OUT_DATA_BITS'(rsp_data_ff);
endmodule

FILE: design/ppd_div.sv
// bit-serial restoring divider, one quotient bit per cycle
module ppd_div #(
   parameter int NUM_W = 84,
   parameter int DEN_W = 34
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] dividend,
   input  logic [DEN_W-1:0] divisor,
   output logic             done,
   output logic [NUM_W-1:0] quotient
);
   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] q_ff;
   logic [DEN_W-1:0] rem_ff;
   logic [DEN_W-1:0] den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;
   logic [DEN_W:0]   rem_sh;
   logic [DEN_W:0]   diff;

   assign rem_sh = {rem_ff, q_ff[NUM_W-1]};
   assign diff   = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(NUM_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         q_ff   <= dividend;
         rem_ff <= '0;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[DEN_W]) begin
            rem_ff <= diff[DEN_W-1:0];
            q_ff   <= {q_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_ff <= rem_sh[DEN_W-1:0];
            q_ff   <= {q_ff[NUM_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = q_ff;
endmodule

FILE: design/ppd_isqrt.sv
// digit-by-digit integer square root, one root bit per cycle
module ppd_isqrt #(
   parameter int RAD_W = 84
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [RAD_W-1:0]   radicand,
   output logic               done,
   output logic [RAD_W/2-1:0] root
);
   localparam int ROOT_W = RAD_W / 2;
   localparam int CNT_W  = $clog2(ROOT_W + 1);

   logic [RAD_W-1:0]  rad_ff;
   logic [ROOT_W:0]   rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              busy_ff;
   logic              done_ff;
   logic [ROOT_W+2:0] rem_sh;
   logic [ROOT_W+2:0] trial;
   logic [ROOT_W+2:0] diff;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {1'b0, root_ff, 2'b01};
   assign diff   = rem_sh - trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(ROOT_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[RAD_W-3:0], 2'b00};
         if (!diff[ROOT_W+2]) begin
            rem_ff  <= diff[ROOT_W:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh[ROOT_W:0];
            root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;
endmodule
